[hdl/i2p_pkg.sv]
// Shared types, constants and helpers for the infix-to-postfix converter.
`default_nettype none

package i2p_pkg;

  localparam int unsigned STACK_DEPTH_DEF = 32;
  localparam int unsigned VALUE_BITS_DEF  = 16;
  localparam int unsigned TOK_BITS        = 3;
  localparam int unsigned KIND_BITS       = 3;
  localparam int unsigned PREC_BITS       = 2;

  // Input token kinds.
  typedef enum logic [TOK_BITS-1:0] {
    TOK_NUMBER   = 3'd0,
    TOK_VARIABLE = 3'd1,
    TOK_FUNCTION = 3'd2,
    TOK_COMMA    = 3'd3,
    TOK_OPERATOR = 3'd4,
    TOK_LPAREN   = 3'd5,
    TOK_RPAREN   = 3'd6,
    TOK_END      = 3'd7
  } tok_e;

  // Emitted / stacked entry kinds.
  typedef enum logic [KIND_BITS-1:0] {
    KIND_NUMBER   = 3'd0,
    KIND_VARIABLE = 3'd1,
    KIND_FUNCTION = 3'd2,
    KIND_OPERATOR = 3'd3,
    KIND_LPAREN   = 3'd4
  } kind_e;

  // Operator codes (low two bits, upper bits zero).
  localparam logic [1:0] OPC_PLUS   = 2'd0;
  localparam logic [1:0] OPC_MINUS  = 2'd1;
  localparam logic [1:0] OPC_TIMES  = 2'd2;
  localparam logic [1:0] OPC_DIVIDE = 2'd3;

  localparam logic [PREC_BITS-1:0] PREC_NONE = 2'd0;
  localparam logic [PREC_BITS-1:0] PREC_ADD  = 2'd1;
  localparam logic [PREC_BITS-1:0] PREC_MUL  = 2'd2;

  // upper_zero: code bits above the low two are all zero.
  function automatic logic [PREC_BITS-1:0] op_prec(input logic       upper_zero,
                                                   input logic [1:0] low);
    logic [PREC_BITS-1:0] p;
    p = PREC_NONE;
    if (upper_zero) begin
      case (low)
        OPC_PLUS, OPC_MINUS:  p = PREC_ADD;
        OPC_TIMES, OPC_DIVIDE: p = PREC_MUL;
        default:              p = PREC_NONE;
      endcase
    end
    return p;
  endfunction

endpackage

`default_nettype wire

[hdl/infix_to_postfix_converter.sv]
// Top level: shunting-yard infix-to-postfix converter with an operator stack memory.
`default_nettype none

// One token is taken at a time; in_ready_o is high only while the sequencer is idle.
// Numbers and plain variables pass decode and finish; pushes end at decode. A comma,
// operator, right parenthesis or end token ends at decode on an empty stack, else
// runs the stack test, popping until it stops. A right parenthesis that drops its
// left parenthesis with entries beneath goes on to test, and possibly pop, the entry
// below. The stack is a memory with one write port and a registered read; the
// sequencer pops one entry per cycle unless the output side holds it. Results pass a
// pending register and an output register; while the output register is held, the
// sequencer stalls at its next emission. The final result of a token carries last_o;
// overflow_o is the sticky flag set when a push found a full stack (token dropped).
module infix_to_postfix_converter #(
  parameter int unsigned STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEF,
  parameter int unsigned VALUE_BITS  = i2p_pkg::VALUE_BITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [i2p_pkg::TOK_BITS-1:0]  op_i,
  input  wire logic [VALUE_BITS-1:0]         value_i,
  input  wire logic                          next_is_lparen_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [i2p_pkg::KIND_BITS-1:0]      out_kind_o,
  output logic [VALUE_BITS-1:0]              out_value_o,
  output logic                               last_o,
  output logic                               overflow_o
);
  import i2p_pkg::*;

  localparam int unsigned AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  typedef struct packed {
    kind_e                 kind;
    logic [VALUE_BITS-1:0] value;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_TEST,
    S_RPFN,
    S_FINISH
  } state_e;

  state_e                state_q, state_d;
  tok_e                  tok_q, tok_d;
  logic [VALUE_BITS-1:0] tok_value_q, tok_value_d;
  logic                  tok_nlp_q, tok_nlp_d;
  logic [CW-1:0]         count_q, count_d;
  logic                  ovf_q, ovf_d;
  logic                  pend_valid_q, pend_valid_d;
  entry_t                pend_q, pend_d;
  logic                  out_valid_q, out_valid_d;
  entry_t                out_q, out_d;
  logic                  last_q, last_d;
  logic                  out_ovf_q, out_ovf_d;

  entry_t                mem [STACK_DEPTH];
  entry_t                rd_q;
  logic [AW-1:0]         rd_addr;
  logic                  push_en;
  entry_t                push_entry;

  logic                  out_free;
  logic                  is_full;
  logic [PREC_BITS-1:0]  tok_prec;
  logic [PREC_BITS-1:0]  top_prec;
  logic                  pop_ok;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_kind_o  = out_q.kind;
  assign out_value_o = out_q.value;
  assign last_o      = last_q;
  assign overflow_o  = out_ovf_q;

  assign out_free = !out_valid_q || out_ready_i;
  assign is_full  = (count_q == CW'(STACK_DEPTH));
  assign tok_prec = op_prec(tok_value_q[VALUE_BITS-1:2] == '0, tok_value_q[1:0]);
  assign top_prec = (rd_q.kind == KIND_OPERATOR)
                  ? op_prec(rd_q.value[VALUE_BITS-1:2] == '0, rd_q.value[1:0])
                  : PREC_NONE;

  always_comb begin
    pop_ok = 1'b0;
    if (count_q != '0) begin
      case (tok_q)
        TOK_COMMA, TOK_RPAREN: pop_ok = (rd_q.kind != KIND_LPAREN);
        TOK_OPERATOR:          pop_ok = (top_prec >= tok_prec);
        TOK_END:               pop_ok = 1'b1;
        default:               pop_ok = 1'b0;
      endcase
    end
  end

  always_comb begin
    state_d      = state_q;
    tok_d        = tok_q;
    tok_value_d  = tok_value_q;
    tok_nlp_d    = tok_nlp_q;
    count_d      = count_q;
    ovf_d        = ovf_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    last_d       = last_q;
    out_ovf_d    = out_ovf_q;
    push_en      = 1'b0;
    push_entry   = '{kind: KIND_OPERATOR, value: tok_value_q};
    rd_addr      = AW'(count_q - CW'(1));

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          tok_d       = tok_e'(op_i);
          tok_value_d = value_i;
          tok_nlp_d   = next_is_lparen_i;
          state_d     = S_DECODE;
        end
      end

      S_DECODE: begin
        state_d = S_IDLE;
        unique case (tok_q)
          TOK_NUMBER: begin
            pend_valid_d = 1'b1;
            pend_d       = '{kind: KIND_NUMBER, value: tok_value_q};
            state_d      = S_FINISH;
          end
          TOK_VARIABLE: begin
            if (tok_nlp_q) begin
              push_entry = '{kind: KIND_FUNCTION, value: tok_value_q};
              push_en    = !is_full;
            end else begin
              pend_valid_d = 1'b1;
              pend_d       = '{kind: KIND_VARIABLE, value: tok_value_q};
              state_d      = S_FINISH;
            end
          end
          TOK_FUNCTION: begin
            push_entry = '{kind: KIND_FUNCTION, value: tok_value_q};
            push_en    = !is_full;
          end
          TOK_LPAREN: begin
            push_entry = '{kind: KIND_LPAREN, value: tok_value_q};
            push_en    = !is_full;
          end
          TOK_COMMA, TOK_OPERATOR, TOK_RPAREN, TOK_END: begin
            if (count_q != '0) begin
              state_d = S_TEST;
            end else if (tok_q == TOK_OPERATOR) begin
              push_en = 1'b1;
            end
          end
        endcase
        if ((tok_q == TOK_FUNCTION || tok_q == TOK_LPAREN ||
             (tok_q == TOK_VARIABLE && tok_nlp_q)) && is_full) begin
          ovf_d = 1'b1;
        end
      end

      S_TEST: begin
        if (pop_ok) begin
          // flush the held entry before taking the next one
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_d       = pend_q;
              last_d      = 1'b0;
              out_ovf_d   = ovf_q;
            end
            pend_valid_d = 1'b1;
            pend_d       = rd_q;
            count_d      = count_q - CW'(1);
            rd_addr      = AW'(count_q - CW'(2));
          end
        end else begin
          state_d = S_FINISH;
          if (tok_q == TOK_OPERATOR) begin
            if (is_full) begin
              ovf_d = 1'b1;
            end else begin
              push_en = 1'b1;
            end
          end else if (tok_q == TOK_RPAREN && count_q != '0 &&
                       rd_q.kind == KIND_LPAREN) begin
            count_d = count_q - CW'(1);
            rd_addr = AW'(count_q - CW'(2));
            if (count_q > CW'(1)) begin
              state_d = S_RPFN;
            end
          end
        end
      end

      S_RPFN: begin
        if (rd_q.kind == KIND_FUNCTION) begin
          if (!pend_valid_q || out_free) begin
            if (pend_valid_q) begin
              out_valid_d = 1'b1;
              out_d       = pend_q;
              last_d      = 1'b0;
              out_ovf_d   = ovf_q;
            end
            pend_valid_d = 1'b1;
            pend_d       = rd_q;
            count_d      = count_q - CW'(1);
            state_d      = S_FINISH;
          end
        end else begin
          state_d = S_FINISH;
        end
      end

      S_FINISH: begin
        if (!pend_valid_q) begin
          state_d = S_IDLE;
        end else if (out_free) begin
          out_valid_d  = 1'b1;
          out_d        = pend_q;
          last_d       = 1'b1;
          out_ovf_d    = ovf_q;
          pend_valid_d = 1'b0;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase

    if (push_en) begin
      count_d = count_q + CW'(1);
    end
  end

  // Operator stack: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (push_en) begin
      mem[count_q[AW-1:0]] <= push_entry;
    end
    rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      tok_q        <= TOK_NUMBER;
      tok_value_q  <= '0;
      tok_nlp_q    <= 1'b0;
      count_q      <= '0;
      ovf_q        <= 1'b0;
      pend_valid_q <= 1'b0;
      pend_q       <= '{kind: KIND_NUMBER, value: '0};
      out_valid_q  <= 1'b0;
      out_q        <= '{kind: KIND_NUMBER, value: '0};
      last_q       <= 1'b0;
      out_ovf_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      tok_q        <= tok_d;
      tok_value_q  <= tok_value_d;
      tok_nlp_q    <= tok_nlp_d;
      count_q      <= count_d;
      ovf_q        <= ovf_d;
      pend_valid_q <= pend_valid_d;
      pend_q       <= pend_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
      last_q       <= last_d;
      out_ovf_q    <= out_ovf_d;
    end
  end

endmodule

`default_nettype wire

[tb/sv/infix_to_postfix_converter_tb.sv]
// Self-checking testbench for the infix-to-postfix converter: token streams in, RPN checked.
`timescale 1ns / 100ps

module infix_to_postfix_converter_tb;
  import i2p_pkg::*;

  localparam int unsigned VB    = VALUE_BITS_DEF;
  localparam int unsigned DEPTH = STACK_DEPTH_DEF;
  localparam int unsigned SETTLE_CYCLES = 50;  // room for a full stack of pops, with margin

  localparam logic [VB-1:0] ADD_CODE = VB'(OPC_PLUS);
  localparam logic [VB-1:0] SUB_CODE = VB'(OPC_MINUS);
  localparam logic [VB-1:0] MUL_CODE = VB'(OPC_TIMES);
  localparam logic [VB-1:0] DIV_CODE = VB'(OPC_DIVIDE);
  localparam logic [VB-1:0] ODD_CODE = '1;  // any code above divide: precedence 0

  typedef struct packed {
    tok_e          op;
    logic [VB-1:0] value;
    logic          nlp;
  } tok_t;

  typedef struct packed {
    kind_e         kind;
    logic [VB-1:0] value;
    logic          last;
    logic          ovf;
  } rpn_t;

  typedef struct {
    tok_t          tok;
    bit            typed;
    kind_e         kind;
    logic [VB-1:0] value;
  } vec_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [TOK_BITS-1:0]  op_i;
  logic [VB-1:0]        value_i;
  logic                 next_is_lparen_i;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [KIND_BITS-1:0] out_kind_o;
  logic [VB-1:0]        out_value_o;
  logic                 last_o;
  logic                 overflow_o;

  infix_to_postfix_converter #(
    .STACK_DEPTH(DEPTH),
    .VALUE_BITS (VB)
  ) u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .op_i            (op_i),
    .value_i         (value_i),
    .next_is_lparen_i(next_is_lparen_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .out_kind_o      (out_kind_o),
    .out_value_o     (out_value_o),
    .last_o          (last_o),
    .overflow_o      (overflow_o)
  );

  // Operator stack mirror
  kind_e         opstk_kind [DEPTH];
  logic [VB-1:0] opstk_val  [DEPTH];
  int            opstk_depth = 0;
  int            opstk_peak  = 0;
  logic          opstk_ovf   = 1'b0;

  rpn_t pending_rpn_q[$];
  tok_t gen_q[$];

  int snd_idle = 0;
  int rcv_idle = 0;
  int fail_cnt = 0;
  int tokens_sent = 0;
  int rpn_checked = 0;

  vec_row_t dir_vec [0:26];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("** infix_to_postfix_converter: FAILED **");
    $finish;
  end

  function automatic tok_t mk(tok_e op, logic [VB-1:0] v, logic nlp);
    tok_t t;
    t.op    = op;
    t.value = v;
    t.nlp   = nlp;
    return t;
  endfunction

  function automatic int unsigned prec_of(kind_e k, logic [VB-1:0] v);
    if (k != KIND_OPERATOR) return 0;
    case (v)
      ADD_CODE, SUB_CODE: return 1;
      MUL_CODE, DIV_CODE: return 2;
      default:            return 0;
    endcase
  endfunction

  function automatic void stack_push(kind_e k, logic [VB-1:0] v);
    if (opstk_depth >= DEPTH) begin
      opstk_ovf = 1'b1;
    end else begin
      opstk_kind[opstk_depth] = k;
      opstk_val[opstk_depth]  = v;
      opstk_depth++;
      if (opstk_depth > opstk_peak) opstk_peak = opstk_depth;
    end
  endfunction

  function automatic void pop_one(inout rpn_t res[$]);
    rpn_t r;
    opstk_depth--;
    r.kind  = opstk_kind[opstk_depth];
    r.value = opstk_val[opstk_depth];
    r.last  = 1'b0;
    r.ovf   = 1'b0;
    res = {res, r};
  endfunction

  function automatic void pop_to_lparen(inout rpn_t res[$]);
    while (opstk_depth > 0 && opstk_kind[opstk_depth-1] != KIND_LPAREN) pop_one(res);
  endfunction

  // Advances the stack mirror by one token and returns the RPN tokens it releases.
  function automatic void convert_token(input tok_t t, output rpn_t res[$]);
    int unsigned p;
    rpn_t        r;
    res = {};
    r.last = 1'b0;
    r.ovf  = 1'b0;
    r.value = t.value;
    case (t.op)
      TOK_NUMBER: begin
        r.kind = KIND_NUMBER;
        res = {res, r};
      end
      TOK_VARIABLE: begin
        if (t.nlp) begin
          stack_push(KIND_FUNCTION, t.value);
        end else begin
          r.kind = KIND_VARIABLE;
          res = {res, r};
        end
      end
      TOK_FUNCTION: stack_push(KIND_FUNCTION, t.value);
      TOK_COMMA:    pop_to_lparen(res);
      TOK_OPERATOR: begin
        p = prec_of(KIND_OPERATOR, t.value);
        while (opstk_depth > 0 &&
               prec_of(opstk_kind[opstk_depth-1], opstk_val[opstk_depth-1]) >= p)
          pop_one(res);
        stack_push(KIND_OPERATOR, t.value);
      end
      TOK_LPAREN:   stack_push(KIND_LPAREN, t.value);
      TOK_RPAREN: begin
        pop_to_lparen(res);
        if (opstk_depth > 0 && opstk_kind[opstk_depth-1] == KIND_LPAREN) opstk_depth--;
        if (opstk_depth > 0 && opstk_kind[opstk_depth-1] == KIND_FUNCTION) pop_one(res);
      end
      default: begin
        while (opstk_depth > 0) pop_one(res);
      end
    endcase
    foreach (res[i]) res[i].ovf = opstk_ovf;
    if (res.size() > 0) res[res.size()-1].last = 1'b1;
  endfunction

  function automatic void add_tok(tok_t t);
    gen_q = {gen_q, t};
  endfunction

  // Random well-formed infix: operands, parenthesized groups and calls.
  function automatic logic [VB-1:0] rand_opcode();
    if ($urandom_range(0, 99) < 85) return VB'($urandom_range(0, 3));
    return VB'($urandom);
  endfunction

  function automatic void gen_expr(int lvl);
    gen_operand(lvl);
    repeat ($urandom_range(0, 2)) begin
      add_tok(mk(TOK_OPERATOR, rand_opcode(), 1'($urandom)));
      gen_operand(lvl);
    end
  endfunction

  function automatic void gen_args(int lvl);
    gen_expr(lvl + 1);
    repeat ($urandom_range(0, 2)) begin
      add_tok(mk(TOK_COMMA, VB'($urandom), 1'($urandom)));
      gen_expr(lvl + 1);
    end
    add_tok(mk(TOK_RPAREN, VB'($urandom), 1'($urandom)));
  endfunction

  function automatic void gen_operand(int lvl);
    int pick;
    pick = $urandom_range(0, (lvl >= 2) ? 1 : 4);
    case (pick)
      0: add_tok(mk(TOK_NUMBER, VB'($urandom), 1'($urandom)));
      1: add_tok(mk(TOK_VARIABLE, VB'($urandom), 1'b0));
      2: begin
        add_tok(mk(TOK_LPAREN, VB'($urandom), 1'($urandom)));
        gen_expr(lvl + 1);
        add_tok(mk(TOK_RPAREN, VB'($urandom), 1'($urandom)));
      end
      3: begin
        add_tok(mk(TOK_FUNCTION, VB'($urandom), 1'($urandom)));
        add_tok(mk(TOK_LPAREN, VB'($urandom), 1'($urandom)));
        gen_args(lvl);
      end
      default: begin
        // variable used as a call
        add_tok(mk(TOK_VARIABLE, VB'($urandom), 1'b1));
        add_tok(mk(TOK_LPAREN, VB'($urandom), 1'($urandom)));
        gen_args(lvl);
      end
    endcase
  endfunction

  task automatic send_token(input tok_t t, input bit typed, input rpn_t typed_res);
    rpn_t res[$];
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i       = 1'b1;
    op_i             = t.op;
    value_i          = t.value;
    next_is_lparen_i = t.nlp;
    do @(posedge clk_i); while (!in_ready_o);
    convert_token(t, res);
    if (typed) begin
      res = {typed_res};
    end
    foreach (res[i]) pending_rpn_q = {pending_rpn_q, res[i]};
    tokens_sent++;
    @(negedge clk_i);
  endtask

  // Hold requests off until the output side has caught up and the sequencer settled.
  task automatic drain();
    in_valid_i = 1'b0;
    while (pending_rpn_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic run_random(int n_tok, int s_idle, int r_idle);
    int target;
    int r;
    snd_idle = s_idle;
    rcv_idle = r_idle;
    target   = tokens_sent + n_tok;
    while (tokens_sent < target) begin
      gen_q = {};
      r = $urandom_range(0, 99);
      if (r < 15) begin
        repeat ($urandom_range(1, 4))
          add_tok(mk(tok_e'($urandom_range(0, 7)), VB'($urandom), 1'($urandom)));
      end else begin
        gen_expr(0);
        add_tok(mk(TOK_END, VB'($urandom), 1'($urandom)));
        // broken expression: one token lost
        if (r < 27) gen_q.delete($urandom_range(0, gen_q.size() - 1));
      end
      foreach (gen_q[i]) send_token(gen_q[i], 1'b0, '0);
    end
  endtask

  always @(negedge clk_i) begin
    out_ready_i = ($urandom_range(0, 99) >= rcv_idle);
  end

  always @(posedge clk_i) begin : rpn_check
    rpn_t want;
    bit   bad;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_rpn_q.size() == 0) begin
        $error("unexpected result: kind %0d value 0x%0h", out_kind_o, out_value_o);
        fail_cnt++;
      end else begin
        want = pending_rpn_q.pop_front();
        bad  = 1'b0;
        rpn_checked++;
        if (out_kind_o !== want.kind) begin
          $error("out_kind: expected %0d, got %0d", want.kind, out_kind_o);
          bad = 1'b1;
        end
        if (out_value_o !== want.value) begin
          $error("out_value: expected 0x%0h, got 0x%0h", want.value, out_value_o);
          bad = 1'b1;
        end
        if (last_o !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, last_o);
          bad = 1'b1;
        end
        if (overflow_o !== want.ovf) begin
          $error("overflow: expected %0b, got %0b", want.ovf, overflow_o);
          bad = 1'b1;
        end
        if (bad) fail_cnt++;
      end
    end
  end

  initial begin
    rst_ni           = 1'b0;
    in_valid_i       = 1'b0;
    op_i             = TOK_NUMBER;
    value_i          = '0;
    next_is_lparen_i = 1'b0;

    // Plain operands, f(a, b + c * d) - g(7 / 3), then operator, comma and rparen corner cases
    dir_vec = '{
      '{'{TOK_NUMBER,   16'h0000, 1'b0}, 1'b1, KIND_NUMBER,   16'h0000},
      '{'{TOK_NUMBER,   16'hFFFF, 1'b1}, 1'b1, KIND_NUMBER,   16'hFFFF},
      '{'{TOK_VARIABLE, 16'h8001, 1'b0}, 1'b1, KIND_VARIABLE, 16'h8001},
      '{'{TOK_FUNCTION, 16'h0AAA, 1'b1}, 1'b0, KIND_NUMBER,   16'h0000},
      '{'{TOK_LPAREN,   16'h0000, 1'b0}, 1'b0, KIND_NUMBER,   16'h0000},
      '{'{TOK_VARIABLE, 16'h00A1, 1'b0}, 1'b1, KIND_VARIABLE, 16'h00A1},
      '{'{TOK_COMMA,    16'h0000, 1'b0}, 1'b0, KIND_NUMBER,   16'h0000},
      '{'{TOK_VARIABLE, 16'h00B2, 1'b0}, 1'b1, KIND_VARIABLE, 16'h00B2},
      '{'{TOK_OPERATOR, ADD_CODE, 1'b0}, 1'b0, KIND_NUMBER,   16'h0000},
      '{'{TOK_VARIABLE, 16'h00C3, 1'b0}, 1'b1, KIND_VARIABLE, 16'h00C3},
      '{'{TOK_OPERATOR, MUL_CODE, 1'b1}, 1'b0, KIND_NUMBER,   16'h0000},
      '{'{TOK_VARIABLE, 16'h00D4, 1'b0}, 1'b1, KIND_VARIABLE, 16'h00D4},
      '{'{TOK_RPAREN,   16'h0000, 1'b0}, 1'b0, KIND_NUMBER,   16'h0000},
      '{'{TOK_OPERATOR, SUB_CODE, 1'b0}, 1'b0, KIND_NUMBER,   16'h0000},
      '{'{TOK_VARIABLE, 16'h5555, 1'b1}, 1'b0, KIND_NUMBER,   16'h0000},
      '{'{TOK_LPAREN,   16'h0000, 1'b0}, 1'b0, KIND_NUMBER,   16'h0000},
      '{'{TOK_NUMBER,   16'h0007, 1'b0}, 1'b1, KIND_NUMBER,   16'h0007},
      '{'{TOK_OPERATOR, DIV_CODE, 1'b0}, 1'b0, KIND_NUMBER,   16'h0000},
      '{'{TOK_NUMBER,   16'h0003, 1'b0}, 1'b1, KIND_NUMBER,   16'h0003},
      '{'{TOK_RPAREN,   16'h0000, 1'b1}, 1'b0, KIND_NUMBER,   16'h0000},
      '{'{TOK_LPAREN,   16'hFFFF, 1'b0}, 1'b0, KIND_NUMBER,   16'h0000},
      '{'{TOK_OPERATOR, ODD_CODE, 1'b0}, 1'b0, KIND_NUMBER,   16'h0000},
      '{'{TOK_COMMA,    16'hFFFF, 1'b1}, 1'b0, KIND_NUMBER,   16'h0000},
      '{'{TOK_OPERATOR, MUL_CODE, 1'b0}, 1'b0, KIND_NUMBER,   16'h0000},
      '{'{TOK_RPAREN,   16'hFFFF, 1'b0}, 1'b0, KIND_NUMBER,   16'h0000},
      '{'{TOK_LPAREN,   16'h1234, 1'b0}, 1'b0, KIND_NUMBER,   16'h0000},
      '{'{TOK_END,      16'hFFFF, 1'b1}, 1'b0, KIND_NUMBER,   16'h0000}
    };

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    rcv_idle = 30;
    foreach (dir_vec[i])
      send_token(dir_vec[i].tok, dir_vec[i].typed,
                 '{kind: dir_vec[i].kind, value: dir_vec[i].value, last: 1'b1, ovf: 1'b0});
    drain();

    run_random(130, 32, 72);
    drain();
    run_random(130, 72, 32);
    drain();
    run_random(130, 0, 0);
    drain();

    // fill the stack past its depth, then flush it all
    send_token(mk(TOK_END, '0, 1'b0), 1'b0, '0);
    repeat (DEPTH + 2) send_token(mk(TOK_FUNCTION, VB'($urandom), 1'($urandom)), 1'b0, '0);
    send_token(mk(TOK_END, VB'($urandom), 1'b0), 1'b0, '0);
    drain();

    $display("Run covered %0d tokens and %0d postfix results; stack peaked at %0d of %0d.",
             tokens_sent, rpn_checked, opstk_peak, DEPTH);
    $display("Sticky overflow %0s; %0d failing results.",
             opstk_ovf ? "reached" : "never reached", fail_cnt);
    if (fail_cnt == 0) begin
      $display("** infix_to_postfix_converter: PASSED **");
    end else begin
      $display("** infix_to_postfix_converter: FAILED **");
    end
    $finish;
  end

endmodule

[files.f]
hdl/i2p_pkg.sv
hdl/infix_to_postfix_converter.sv
tb/sv/infix_to_postfix_converter_tb.sv
